// ----- rtl/rds_group_time_name_decoder_core_assert.svh -----
// Assertion macros shared by the checker.
`ifndef RDS_GROUP_TIME_NAME_DECODER_CORE_ASSERT_SVH
`define RDS_GROUP_TIME_NAME_DECODER_CORE_ASSERT_SVH

// Same-cycle implication.
`define RGTN_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RGTN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/rgtn_pkg.sv -----
package rgtn_pkg;

  localparam int NameChars = 8;
  localparam int CharW     = 7;
  localparam int NameIdxW  = 3;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 8;

  localparam logic [7:0]  StartReset = 8'd30;
  localparam logic [7:0]  LimitReset = 8'd60;
  localparam logic [6:0]  CharDot    = 7'h2E;
  localparam logic [6:0]  CharSpace  = 7'h20;
  localparam logic [16:0] DayMin     = 17'd57388;
  localparam logic [16:0] DayMax     = 17'd88068;
  localparam logic [4:0]  HourMax    = 5'd23;
  localparam logic [5:0]  MinuteMax  = 6'd59;
  localparam logic signed [5:0] OffMin = -6'sd24;
  localparam logic signed [5:0] OffMax = 6'sd28;
  localparam logic [3:0]  TypeName   = 4'd0;
  localparam logic [3:0]  TypeTime   = 4'd4;

  localparam logic [CfgIdxW-1:0] CfgTimeoutStart = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgTimeoutLimit = 1'd1;

  typedef enum logic [2:0] {
    ST_NONE, ST_REJECT, ST_EBLOCK, ST_NAME, ST_BAD_CHARS, ST_TIME, ST_BAD_TIME, ST_OTHER
  } status_t;

  typedef struct packed {
    logic        cmd;
    logic        tick;
    logic        rds_ready;
    logic        rds_sync;
    logic [3:0]  bit_errors;
    logic        block_e;
    logic [15:0] group_b;
    logic [15:0] group_c;
    logic [15:0] group_d;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        timed_out;
    logic [1:0]  segment;
    logic [55:0] name_text;
    logic [16:0] local_day;
    logic [4:0]  local_hour;
    logic [5:0]  local_minute;
  } out_item_t;

  // group classification handed from the decoder to the core
  typedef struct packed {
    status_t     status;
    logic        good;
    logic [1:0]  segment;
    logic [6:0]  char_hi;
    logic [6:0]  char_lo;
    logic [16:0] day;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } decode_t;

  function automatic logic char_ok(input logic [6:0] c);
    logic ok;
    ok = (c >= 7'h41 && c <= 7'h5A) || (c >= 7'h61 && c <= 7'h7A) ||
         (c >= 7'h30 && c <= 7'h39) || c == CharSpace || c == 7'h21 || c == 7'h3F;
    return ok;
  endfunction

endpackage

// ----- rtl/rgtn_decode.sv -----
module rgtn_decode (
  input  rgtn_pkg::in_item_t item,
  output rgtn_pkg::decode_t  dec
);
  import rgtn_pkg::*;

  logic [3:0]         gtype;
  logic [6:0]         c1, c2;
  logic [16:0]        day;
  logic [4:0]         hr;
  logic [5:0]         mn;
  logic signed [5:0]  off;
  logic signed [5:0]  off_half;
  logic [6:0]         min_sum;
  logic               carry;
  logic [6:0]         min_adj;
  logic signed [6:0]  hr_sum;
  logic               time_ok;

  assign gtype = item.group_b[15:12];
  assign c1    = item.group_d[14:8];
  assign c2    = item.group_d[6:0];
  assign day   = {item.group_b[1:0], item.group_c[15:1]};
  assign hr    = {item.group_c[0], item.group_d[15:12]};
  assign mn    = item.group_d[11:6];
  assign off   = $signed(item.group_d[5:0]);

  assign time_ok = day >= DayMin && day <= DayMax && hr <= HourMax && mn <= MinuteMax &&
                   off >= OffMin && off <= OffMax;

  // odd half-hour offsets add 30 minutes; whole hours go to the hour
  assign off_half = off >>> 1;
  assign min_sum  = {1'b0, mn} + (off[0] ? 7'd30 : 7'd0);
  assign carry    = min_sum >= 7'd60;
  assign min_adj  = carry ? min_sum - 7'd60 : min_sum;
  assign hr_sum   = $signed({2'b00, hr}) + {off_half[5], off_half} + $signed({6'd0, carry});

  always_comb begin
    dec         = '0;
    dec.status  = ST_OTHER;
    dec.char_hi = (c1 == CharSpace) ? CharDot : c1;
    dec.char_lo = (c2 == CharSpace) ? CharDot : c2;
    dec.segment = item.group_b[1:0];
    if (!item.rds_sync || item.bit_errors != 4'd0) begin
      dec.status = ST_REJECT;
    end else if (item.block_e) begin
      dec.status = ST_EBLOCK;
    end else if (gtype == TypeName) begin
      dec.status = (char_ok(c1) && char_ok(c2)) ? ST_NAME : ST_BAD_CHARS;
    end else if (gtype == TypeTime && !item.group_b[11]) begin
      dec.status = time_ok ? ST_TIME : ST_BAD_TIME;
    end
    dec.good   = dec.status == ST_NAME || dec.status == ST_TIME;
    dec.minute = min_adj[5:0];
    if (hr_sum < 0) begin
      dec.hour = 5'(hr_sum + 7'sd24);
      dec.day  = day - 17'd1;
    end else if (hr_sum >= 7'sd24) begin
      dec.hour = 5'(hr_sum - 7'sd24);
      dec.day  = day + 17'd1;
    end else begin
      dec.hour = hr_sum[4:0];
      dec.day  = day;
    end
  end

endmodule

// ----- rtl/rds_group_time_name_decoder_core.sv -----
// RDS group 0 / 4A decoder core.
// Input register, then result register; the state update is a single pass between the two.
// Throughput: one item per cycle while the output is not stalled by out_ready low.
// Reset (synchronous, rst high): name to dots, last block B to zero, timeout counter and
// timeout_start to 30, timeout_limit to 60, both pipeline registers empty.
module rds_group_time_name_decoder_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rgtn_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [rgtn_pkg::CfgDataW-1:0]   cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rgtn_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rgtn_pkg::out_item_t             out_data
);
  import rgtn_pkg::*;

  logic        s1_valid;
  in_item_t    s1_item;
  logic        adv;
  decode_t     dec;

  logic [7:0]  timeout_start, timeout_limit;
  logic [7:0]  timeout_count, timeout_count_next, count_tick;
  logic [15:0] previous_block_b, previous_block_b_next;
  logic [6:0]  station_name      [NameChars];
  logic [6:0]  station_name_next [NameChars];
  out_item_t   res;

  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || adv;

  rgtn_decode u_decode (
    .item (s1_item),
    .dec  (dec)
  );

  assign count_tick = (s1_item.tick && timeout_count != 8'd0) ? timeout_count - 8'd1
                                                              : timeout_count;

  always_comb begin
    timeout_count_next    = timeout_count;
    previous_block_b_next = previous_block_b;
    station_name_next     = station_name;
    res                   = '0;
    if (s1_item.cmd) begin
      for (int i = 0; i < NameChars; i++) station_name_next[i] = CharDot;
      previous_block_b_next = '0;
      timeout_count_next    = timeout_start;
    end else if (timeout_count != 8'd0) begin
      timeout_count_next = count_tick;
      if (s1_item.rds_ready && s1_item.group_b != previous_block_b) begin
        previous_block_b_next = s1_item.group_b;
        res.status            = dec.status;
        if (dec.good && count_tick < timeout_limit) begin
          timeout_count_next = count_tick + 8'd1;
        end
        if (dec.status == ST_NAME) begin
          station_name_next[{dec.segment, 1'b0}] = dec.char_hi;
          station_name_next[{dec.segment, 1'b1}] = dec.char_lo;
          res.segment = dec.segment;
        end
        if (dec.status == ST_TIME) begin
          res.local_day    = dec.day;
          res.local_hour   = dec.hour;
          res.local_minute = dec.minute;
        end
      end
    end
    res.timed_out = timeout_count_next == 8'd0;
    for (int i = 0; i < NameChars; i++) res.name_text[i*CharW +: CharW] = station_name_next[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      out_valid        <= 1'b0;
      timeout_start    <= StartReset;
      timeout_limit    <= LimitReset;
      timeout_count    <= StartReset;
      previous_block_b <= '0;
      for (int i = 0; i < NameChars; i++) station_name[i] <= CharDot;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (adv) begin
        out_valid        <= 1'b1;
        timeout_count    <= timeout_count_next;
        previous_block_b <= previous_block_b_next;
        station_name     <= station_name_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CfgTimeoutStart: timeout_start <= cfg_data;
          CfgTimeoutLimit: timeout_limit <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_item <= in_data;
    if (adv) out_data <= res;
  end

endmodule

// ----- rtl/rgtn_checker.sv -----
`include "rds_group_time_name_decoder_core_assert.svh"

module rgtn_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input rgtn_pkg::out_item_t  out_data
);
  import rgtn_pkg::*;

  `RGTN_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "result item changed while stalled")
  `RGTN_ASSERT_NOW(a_seg_zero, clk, rst, out_valid && out_data.status != ST_NAME, out_data.segment == 2'd0, "segment set without a stored name")
  `RGTN_ASSERT_NOW(a_time_zero, clk, rst, out_valid && out_data.status != ST_TIME, out_data.local_day == 17'd0 && out_data.local_hour == 5'd0 && out_data.local_minute == 6'd0, "local time set without a decoded time")
  `RGTN_ASSERT_NOW(a_time_range, clk, rst, out_valid && out_data.status == ST_TIME, out_data.local_hour <= 5'd23 && out_data.local_minute <= 6'd59, "local time out of range")

endmodule

bind rds_group_time_name_decoder_core rgtn_checker u_rgtn_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
